// File: src/alignment_hit_dedup_table_core_macros.svh
// ----------------------------------------------------------------------------
// Alignment hit dedup table assertion macros
// Shared concurrent assertion forms for the dedup table RTL.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_HIT_DEDUP_TABLE_CORE_MACROS_SVH
`define ALIGNMENT_HIT_DEDUP_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define AHDT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is active
`define AHDT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/ahdt_pkg.sv
// ----------------------------------------------------------------------------
// Alignment hit dedup table package
// Transaction types, status codes, sequencer states and tolerance constants.
// ----------------------------------------------------------------------------
package ahdt_pkg;

    // Input transaction: one alignment hit
    typedef struct packed {
        logic [23:0] query_index;
        logic [23:0] subject_index;
        logic [30:0] query_start;
        logic [30:0] query_end;
        logic [30:0] subject_start;
        logic [30:0] subject_end;
        logic [30:0] hit_length;
    } t_hit_in;

    // Output transaction: status and running accepted count
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] accepted_total;
    } t_hit_out;

    // Stored hit record
    typedef struct packed {
        logic [30:0] query_start;
        logic [30:0] query_end;
        logic [30:0] subject_start;
        logic [30:0] subject_end;
        logic [30:0] hit_length;
    } t_rec;

    // Stored pair key
    typedef struct packed {
        logic [23:0] query_index;
        logic [23:0] subject_index;
    } t_key;

    // Status codes
    localparam logic [1:0] STAT_NEW    = 2'd0;
    localparam logic [1:0] STAT_APPEND = 2'd1;
    localparam logic [1:0] STAT_DUP    = 2'd2;
    localparam logic [1:0] STAT_FULL   = 2'd3;

    localparam logic [31:0] TOTAL_MAX = 32'hFFFF_FFFF;

    // Tolerance is min(len)/20, done as (min >> 2) / 5. The quotient by five
    // uses ceil(2^32/5); it is exact for dividends below 2^30.
    localparam int          TOL_PRE_SHIFT = 2;
    localparam logic [29:0] TOL_RECIP     = 30'd858993460;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_REC_RD,
        ST_REC_TOL,
        ST_REC_CMP,
        ST_WRITE
    } t_state;

    // Build a stored record from an input hit
    function automatic t_rec to_rec(input t_hit_in hit);
        t_rec rec;
        rec.query_start   = hit.query_start;
        rec.query_end     = hit.query_end;
        rec.subject_start = hit.subject_start;
        rec.subject_end   = hit.subject_end;
        rec.hit_length    = hit.hit_length;
        return rec;
    endfunction

endpackage

// File: src/ahdt_tol_cmp.sv
// ----------------------------------------------------------------------------
// Alignment hit dedup tolerance compare unit
// Registers min(len)/20 through a reciprocal multiply, then tests containment.
// ----------------------------------------------------------------------------
module ahdt_tol_cmp
    import ahdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_load,
    input  t_rec i_new,
    input  t_rec i_old,
    output logic o_dup
);

    logic [30:0] min_len;
    logic [28:0] quarter;
    logic [58:0] n_prod;
    logic [58:0] r_prod;
    logic [26:0] tol;
    logic [31:0] tol2;
    logic        on_query;
    logic        on_subject;

    // Scale the shorter length by 1/20
    always_comb begin
        min_len = (i_new.hit_length < i_old.hit_length) ? i_new.hit_length
                                                        : i_old.hit_length;
        quarter = min_len[30:TOL_PRE_SHIFT];
        n_prod  = 59'(quarter) * 59'(TOL_RECIP);
    end

    // Hold the product for the compare cycle
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // Test containment: start + tol >= old start - tol, end - tol <= old end + tol
    always_comb begin
        tol  = r_prod[58:32];
        tol2 = {4'd0, tol, 1'b0};
        on_query   = (({1'b0, i_new.query_start} + tol2) >= {1'b0, i_old.query_start}) &&
                     ({1'b0, i_new.query_end} <= ({1'b0, i_old.query_end} + tol2));
        on_subject = (({1'b0, i_new.subject_start} + tol2) >= {1'b0, i_old.subject_start}) &&
                     ({1'b0, i_new.subject_end} <= ({1'b0, i_old.subject_end} + tol2));
        o_dup = on_query && on_subject;
    end

endmodule

// File: src/alignment_hit_dedup_table_core.sv
// ----------------------------------------------------------------------------
// Alignment hit dedup table core
// Pair lookup, duplicate scan and append of alignment hits.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a hit on i_hit and raise i_start; the transaction is taken on a
//   clock edge where o_busy is low. One result comes back on o_result,
//   valid for exactly one cycle while o_done is high; it cannot be held off.
// Sequence per hit:
//   Pair lookup reads the pair table one entry a cycle and stops at the
//   first match; a new pair scans every entry. Each stored hit of a known
//   pair then passes through the shared tolerance unit as a read, a
//   multiply and a compare, and the scan stops at a duplicate; on reaching
//   the end of the slot a store follows unless the slot is full. The
//   result strobe is registered from the sequencer's finish. A new hit is
//   taken on the cycle the result is shown.
// Reset:
//   Clears all pair valid bits and the accepted count and holds o_busy high;
//   stored keys and records need no clearing since a pair is only read once
//   marked valid.
// ----------------------------------------------------------------------------
`include "alignment_hit_dedup_table_core_macros.svh"

module alignment_hit_dedup_table_core
    import ahdt_pkg::*;
#(
    parameter int PAIR_SLOTS    = 64,
    parameter int HITS_PER_PAIR = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_hit_in  i_hit,
    output logic     o_busy,
    output logic     o_done,
    output t_hit_out o_result
);

    localparam int PW  = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int CW  = $clog2(PAIR_SLOTS + 1);
    localparam int FW  = $clog2(HITS_PER_PAIR + 1);
    localparam int RD  = PAIR_SLOTS * HITS_PER_PAIR;
    localparam int RW  = (RD > 1) ? $clog2(RD) : 1;

    // Storage
    t_key         m_key  [PAIR_SLOTS];
    logic [FW-1:0] m_fill [PAIR_SLOTS];
    t_rec         m_rec  [RD];

    // Sequencer and datapath registers
    t_state          r_state, n_state;
    t_hit_in         r_hit;
    logic [CW-1:0]   r_scan;
    logic            r_rd_live;
    logic [PW-1:0]   r_rd_idx;
    logic            r_rd_vld;
    t_key            r_key_rd;
    logic [FW-1:0]   r_fill_rd;
    logic            r_have_free;
    logic [PW-1:0]   r_free;
    logic [PW-1:0]   r_tgt;
    logic [RW-1:0]   r_base;
    logic [FW-1:0]   r_fill;
    logic [FW-1:0]   r_k;
    logic            r_new;
    t_rec            r_rec_rd;
    logic [31:0]     r_total, n_total;
    t_hit_out        r_out;
    logic            r_done;
    logic [PAIR_SLOTS-1:0] r_valid;

    // Decoded control
    logic          accept;
    logic          scan_issue;
    logic          cur_match;
    logic          cur_free;
    logic          scan_last;
    logic          pair_hit;
    logic          pair_new;
    logic [PW-1:0] new_idx;
    logic          rec_issue;
    logic          tol_load;
    logic          k_step;
    logic          wr_en;
    logic          finish;
    logic [1:0]    fin_status;
    logic          dup;
    logic [RW-1:0] rec_addr;
    logic [PW-1:0] scan_idx;

    ahdt_tol_cmp u_tol_cmp (
        .i_clk  (i_clk),
        .i_load (tol_load),
        .i_new  (to_rec(r_hit)),
        .i_old  (r_rec_rd),
        .o_dup  (dup)
    );

    assign accept   = i_start && !o_busy;
    assign scan_idx = r_scan[PW-1:0];

    // Compare the pair entry read in the previous cycle
    always_comb begin
        cur_match = r_rd_live && r_rd_vld &&
                    (r_key_rd.query_index == r_hit.query_index) &&
                    (r_key_rd.subject_index == r_hit.subject_index);
        cur_free  = r_rd_live && !r_rd_vld;
        scan_last = r_rd_live && (r_rd_idx == PW'(PAIR_SLOTS - 1));
        new_idx   = r_have_free ? r_free : r_rd_idx;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (cur_match) begin
                    n_state = ST_REC_RD;
                end else if (scan_last) begin
                    n_state = (cur_free || r_have_free) ? ST_WRITE : ST_IDLE;
                end
            end
            ST_REC_RD: begin
                if (r_k == r_fill) begin
                    n_state = (r_fill == FW'(HITS_PER_PAIR)) ? ST_IDLE : ST_WRITE;
                end else begin
                    n_state = ST_REC_TOL;
                end
            end
            ST_REC_TOL: n_state = ST_REC_CMP;
            ST_REC_CMP: n_state = dup ? ST_IDLE : ST_REC_RD;
            ST_WRITE:   n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        scan_issue = 1'b0;
        pair_hit   = 1'b0;
        pair_new   = 1'b0;
        rec_issue  = 1'b0;
        tol_load   = 1'b0;
        k_step     = 1'b0;
        wr_en      = 1'b0;
        finish     = 1'b0;
        fin_status = STAT_FULL;
        case (r_state)
            ST_PAIR: begin
                scan_issue = (r_scan < CW'(PAIR_SLOTS));
                pair_hit   = cur_match;
                pair_new   = !cur_match && scan_last && (cur_free || r_have_free);
                if (!cur_match && scan_last && !(cur_free || r_have_free)) begin
                    finish     = 1'b1;
                    fin_status = STAT_FULL;
                end
            end
            ST_REC_RD: begin
                if (r_k != r_fill) begin
                    rec_issue = 1'b1;
                end else if (r_fill == FW'(HITS_PER_PAIR)) begin
                    finish     = 1'b1;
                    fin_status = STAT_FULL;
                end
            end
            ST_REC_TOL: tol_load = 1'b1;
            ST_REC_CMP: begin
                k_step = !dup;
                if (dup) begin
                    finish     = 1'b1;
                    fin_status = STAT_DUP;
                end
            end
            ST_WRITE: begin
                wr_en      = 1'b1;
                finish     = 1'b1;
                fin_status = r_new ? STAT_NEW : STAT_APPEND;
            end
            default: ;
        endcase
    end

    // Saturating accepted count
    always_comb begin
        n_total = r_total;
        if (((fin_status == STAT_NEW) || (fin_status == STAT_APPEND)) &&
            (r_total != TOTAL_MAX)) begin
            n_total = r_total + 32'd1;
        end
    end

    assign rec_addr = r_base + RW'(wr_en ? r_fill : r_k);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_total   <= '0;
            r_done    <= 1'b0;
            r_rd_live <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= finish;
            r_rd_live <= scan_issue;
            if (finish) begin
                r_total <= n_total;
            end
            if (wr_en) begin
                r_valid[r_tgt] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit       <= i_hit;
            r_scan      <= '0;
            r_have_free <= 1'b0;
        end
        if (scan_issue) begin
            r_scan   <= r_scan + CW'(1);
            r_rd_idx <= scan_idx;
            r_rd_vld <= r_valid[scan_idx];
        end
        // Remember the lowest free entry
        if ((r_state == ST_PAIR) && cur_free && !r_have_free) begin
            r_have_free <= 1'b1;
            r_free      <= r_rd_idx;
        end
        if (pair_hit) begin
            r_tgt  <= r_rd_idx;
            r_base <= RW'(r_rd_idx * HITS_PER_PAIR);
            r_fill <= r_fill_rd;
            r_k    <= '0;
            r_new  <= 1'b0;
        end
        if (pair_new) begin
            r_tgt  <= new_idx;
            r_base <= RW'(new_idx * HITS_PER_PAIR);
            r_fill <= '0;
            r_new  <= 1'b1;
        end
        if (k_step) begin
            r_k <= r_k + FW'(1);
        end
        if (finish) begin
            r_out.status         <= fin_status;
            r_out.accepted_total <= n_total;
        end
    end

    // Pair table memory
    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_key_rd  <= m_key[scan_idx];
            r_fill_rd <= m_fill[scan_idx];
        end
        if (wr_en) begin
            m_key[r_tgt]  <= '{query_index: r_hit.query_index,
                               subject_index: r_hit.subject_index};
            m_fill[r_tgt] <= r_fill + FW'(1);
        end
    end

    // Hit record memory
    always_ff @(posedge i_clk) begin
        if (rec_issue) begin
            r_rec_rd <= m_rec[rec_addr];
        end
        if (wr_en) begin
            m_rec[rec_addr] <= to_rec(r_hit);
        end
    end

    // Hold busy through reset so no transaction is taken and dropped
    assign o_busy   = !i_rst_n || (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

    // Result strobe only follows a finished transaction
    `AHDT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, r_state == ST_IDLE)
    // A taken transaction starts the pair scan
    `AHDT_ASSERT_NXT(a_accept_scan, i_clk, i_rst_n, i_start && !o_busy, r_state == ST_PAIR)
    // The record scan never runs past the slot fill
    `AHDT_ASSERT_IMP(a_k_bound, i_clk, i_rst_n, r_state == ST_REC_RD, r_k <= r_fill)
    // A store always lands below the slot limit
    `AHDT_ASSERT_IMP(a_wr_room, i_clk, i_rst_n, r_state == ST_WRITE,
                     r_fill < FW'(HITS_PER_PAIR))
    // An accepted hit leaves a nonzero count
    `AHDT_ASSERT_IMP(a_total_nz, i_clk, i_rst_n,
                     r_done && ((r_out.status == STAT_NEW) || (r_out.status == STAT_APPEND)),
                     r_out.accepted_total != 32'd0)

endmodule
